// ----- design/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the stuffed frame packer
// Token format between front and back, frame byte codes, register indexes.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int unsigned MAX_PAYLOAD = 8;
    localparam int unsigned ID_W        = 30;
    localparam int unsigned PAY_W       = 64;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    // token queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // token positions in a frame
    localparam int unsigned IDX_W       = 5;
    localparam logic [IDX_W-1:0] IDX_ID0   = 5'd2;
    localparam logic [IDX_W-1:0] IDX_ID3   = 5'd5;
    localparam logic [IDX_W-1:0] IDX_PAY0  = 5'd6;
    localparam logic [IDX_W-1:0] IDX_PAY7  = 5'd13;
    localparam logic [IDX_W-1:0] IDX_LEN0  = 5'd14;
    localparam logic [IDX_W-1:0] IDX_LEN3  = 5'd17;
    localparam logic [IDX_W-1:0] IDX_CHAN  = 5'd18;
    localparam logic [IDX_W-1:0] IDX_FMT   = 5'd19;
    localparam logic [IDX_W-1:0] IDX_FTYPE = 5'd20;
    localparam logic [IDX_W-1:0] IDX_CKSUM = 5'd21;
    localparam logic [IDX_W-1:0] IDX_TAIL0 = 5'd22;
    localparam logic [IDX_W-1:0] IDX_LAST  = 5'd23;

    localparam logic [BYTE_W-1:0] HEAD_BYTE    = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE    = 8'h55;
    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'hA5;
    localparam logic [BYTE_W-1:0] FMT_EXTENDED = 8'h01;
    localparam logic [BYTE_W-1:0] FRAME_DATA   = 8'h00;
    localparam logic [BYTE_W-1:0] PAD_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0] CHANNEL_RESET = 8'h35;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

    // configuration register indexes
    localparam logic CFG_SEND_CHECKSUM = 1'b0;
    localparam logic CFG_CHANNEL_CODE  = 1'b1;

    // how the back end treats a token
    typedef enum logic [2:0] {
        K_PLAIN = 3'd0,  // sent as is, not summed
        K_DATA  = 3'd1,  // escaped and summed
        K_FIXED = 3'd2,  // summed, never escaped
        K_CKSUM = 3'd3,  // replaced by checksum, or zero when disabled
        K_LAST  = 3'd4   // final tail byte
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_token;

endpackage

// ----- design/sfp_front.sv -----
// ----------------------------------------------------------------------------
// sfp_front: message intake and token generation
// Holds one message and walks its 24 frame positions, one token per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module sfp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sfp_pkg::ID_W-1:0]      i_message_id,
    input  logic [sfp_pkg::PAY_W-1:0]     i_payload,
    input  logic [sfp_pkg::LEN_W-1:0]     i_payload_length,
    input  logic [sfp_pkg::BYTE_W-1:0]    i_channel_code,
    input  logic                          i_full,
    output logic                          o_push,
    output sfp_pkg::t_token               o_tok
);

    logic                          r_busy, n_busy;
    logic [sfp_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [sfp_pkg::ID_W-1:0]      r_id;
    logic [sfp_pkg::PAY_W-1:0]     r_pay;
    logic [sfp_pkg::LEN_W-1:0]     r_len;
    logic                          accept;
    logic [31:0]                   id_word;
    logic [1:0]                    id_k;
    logic [2:0]                    pay_k;

    assign accept     = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;
    assign o_push     = r_busy && !i_full;
    assign id_word    = {2'b00, r_id};
    assign id_k       = 2'(r_idx - sfp_pkg::IDX_ID0);
    assign pay_k      = 3'(r_idx - sfp_pkg::IDX_PAY0);

    always_comb begin
        o_tok.kind = sfp_pkg::K_PLAIN;
        o_tok.data = sfp_pkg::HEAD_BYTE;
        case (r_idx) inside
            [sfp_pkg::IDX_ID0:sfp_pkg::IDX_ID3]: begin
                o_tok.kind = sfp_pkg::K_DATA;
                o_tok.data = id_word[{id_k, 3'b000} +: 8];
            end
            [sfp_pkg::IDX_PAY0:sfp_pkg::IDX_PAY7]: begin
                if ({1'b0, pay_k} < r_len) begin
                    o_tok.kind = sfp_pkg::K_DATA;
                    o_tok.data = r_pay[{pay_k, 3'b000} +: 8];
                end else begin
                    o_tok.data = sfp_pkg::PAD_BYTE;
                end
            end
            sfp_pkg::IDX_LEN0: begin
                o_tok.kind = sfp_pkg::K_DATA;
                o_tok.data = {4'b0000, r_len};
            end
            [5'(sfp_pkg::IDX_LEN0 + 5'd1):sfp_pkg::IDX_LEN3]: begin
                o_tok.kind = sfp_pkg::K_DATA;
                o_tok.data = 8'h00;
            end
            sfp_pkg::IDX_CHAN: begin
                o_tok.kind = sfp_pkg::K_FIXED;
                o_tok.data = i_channel_code;
            end
            sfp_pkg::IDX_FMT: begin
                o_tok.kind = sfp_pkg::K_FIXED;
                o_tok.data = sfp_pkg::FMT_EXTENDED;
            end
            sfp_pkg::IDX_FTYPE: begin
                o_tok.kind = sfp_pkg::K_FIXED;
                o_tok.data = sfp_pkg::FRAME_DATA;
            end
            sfp_pkg::IDX_CKSUM: begin
                o_tok.kind = sfp_pkg::K_CKSUM;
                o_tok.data = 8'h00;
            end
            sfp_pkg::IDX_TAIL0: begin
                o_tok.data = sfp_pkg::TAIL_BYTE;
            end
            sfp_pkg::IDX_LAST: begin
                o_tok.kind = sfp_pkg::K_LAST;
                o_tok.data = sfp_pkg::TAIL_BYTE;
            end
            default: begin
                // header bytes
                o_tok.kind = sfp_pkg::K_PLAIN;
                o_tok.data = sfp_pkg::HEAD_BYTE;
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (accept) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (o_push) begin
            n_idx = 5'(r_idx + 5'd1);
            if (r_idx == sfp_pkg::IDX_LAST) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // message hold, length saturated to the payload size
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id  <= i_message_id;
            r_pay <= i_payload;
            r_len <= (i_payload_length > sfp_pkg::LEN_MAX) ? sfp_pkg::LEN_MAX
                                                          : i_payload_length;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= sfp_pkg::IDX_LAST))
        else $error("front position beyond frame end");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept) |-> (r_len <= sfp_pkg::LEN_MAX))
        else $error("stored length not saturated");

endmodule

// ----- design/sfp_queue.sv -----
// ----------------------------------------------------------------------------
// sfp_queue: token queue between front and back
// Small register FIFO; head token is shown combinationally.
// ----------------------------------------------------------------------------
module sfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfp_pkg::t_token  i_tok,
    output logic             o_full,
    input  logic             i_pop,
    output sfp_pkg::t_token  o_tok,
    output logic             o_empty
);

    sfp_pkg::t_token                 r_mem [sfp_pkg::QUEUE_DEPTH];
    logic [sfp_pkg::QPTR_W-1:0]      r_wr, r_rd;
    logic [sfp_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == sfp_pkg::QCNT_W'(sfp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = 3'(r_cnt + 3'd1);
        end else if (do_pop && !do_push) begin
            n_cnt = 3'(r_cnt - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= 2'(r_wr + 2'd1);
            end
            if (do_pop) begin
                r_rd <= 2'(r_rd + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= sfp_pkg::QCNT_W'(sfp_pkg::QUEUE_DEPTH))
        && (sfp_pkg::QPTR_W'(r_wr - r_rd) == r_cnt[sfp_pkg::QPTR_W-1:0]))
        else $error("queue count and pointers disagree");

endmodule

// ----- design/sfp_back.sv -----
// ----------------------------------------------------------------------------
// sfp_back: byte stuffing, checksum and output register
// Drains tokens, inserts escape beats, sums the checked bytes.
// ----------------------------------------------------------------------------
module sfp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfp_pkg::t_token              i_tok,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic                         i_send_checksum,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sfp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_frame_end
);

    logic                         r_valid, n_valid;
    logic                         r_esc, n_esc;
    logic [sfp_pkg::BYTE_W-1:0]   r_sum, n_sum;
    logic [sfp_pkg::BYTE_W-1:0]   r_byte, n_byte;
    logic                         r_last, n_last;
    logic                         load;
    logic                         needs_esc;

    assign load      = !r_valid || !i_out_stall;
    assign needs_esc = (i_tok.kind == sfp_pkg::K_DATA)
                       && ((i_tok.data == sfp_pkg::HEAD_BYTE)
                           || (i_tok.data == sfp_pkg::TAIL_BYTE));

    always_comb begin
        n_valid = r_valid;
        n_esc   = r_esc;
        n_sum   = r_sum;
        n_byte  = r_byte;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (needs_esc && !r_esc) begin
                    n_byte = sfp_pkg::ESC_BYTE;
                    n_last = 1'b0;
                    n_esc  = 1'b1;
                end else begin
                    o_pop  = 1'b1;
                    n_esc  = 1'b0;
                    n_byte = i_tok.data;
                    n_last = (i_tok.kind == sfp_pkg::K_LAST);
                    case (i_tok.kind)
                        sfp_pkg::K_DATA, sfp_pkg::K_FIXED: begin
                            n_sum = 8'(r_sum + i_tok.data);
                        end
                        sfp_pkg::K_CKSUM: begin
                            n_byte = i_send_checksum ? r_sum : 8'h00;
                            n_sum  = '0;
                        end
                        default: begin
                            n_sum = r_sum;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_esc   <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_valid <= n_valid;
            r_esc   <= n_esc;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_last;

    a_esc_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (!i_empty && needs_esc && r_valid
                   && (r_byte == sfp_pkg::ESC_BYTE)))
        else $error("escape beat without its data byte waiting");

    a_esc_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esc && !i_out_stall) |=> (r_valid && !r_esc
                                     && ((r_byte == sfp_pkg::HEAD_BYTE)
                                         || (r_byte == sfp_pkg::TAIL_BYTE))))
        else $error("escaped byte did not follow escape beat");

endmodule

// ----- design/stuffed_frame_packer.sv -----
// The first frame byte passes the front's position registers, the queue and the
// back end's output register. Throughput: one output beat per cycle while the
// output is not stalled; a frame is 24 beats plus one escape beat per stuffed byte
// (24..35). The front takes a new message once all 24 tokens of the last are queued.
// Reset (i_rst_n low, synchronous): queue and pipeline emptied, send_checksum
// back to 0 and channel_code back to 0x35.
// ----------------------------------------------------------------------------
// stuffed_frame_packer: byte-stuffed frame encoder
// Front walks the message fields into tokens, a 4-deep queue decouples it
// from the back end, which stuffs, sums and drives the output beats.
// ----------------------------------------------------------------------------
module stuffed_frame_packer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // message channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sfp_pkg::ID_W-1:0]         i_message_id,
    input  logic [sfp_pkg::PAY_W-1:0]        i_payload,
    input  logic [sfp_pkg::LEN_W-1:0]        i_payload_length,
    // byte channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sfp_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_frame_end,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [sfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic                          r_send_checksum;
    logic [sfp_pkg::BYTE_W-1:0]    r_channel_code;

    // front to queue
    sfp_pkg::t_token               push_tok;
    logic                          push;
    logic                          q_full;
    // queue to back
    sfp_pkg::t_token               head_tok;
    logic                          q_empty;
    logic                          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_checksum <= 1'b0;
            r_channel_code  <= sfp_pkg::CHANNEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfp_pkg::CFG_SEND_CHECKSUM: begin
                    r_send_checksum <= i_cfg_data[0];
                end
                sfp_pkg::CFG_CHANNEL_CODE: begin
                    r_channel_code <= i_cfg_data;
                end
                default: begin
                    r_channel_code <= r_channel_code;
                end
            endcase
        end
    end

    // front: one token per frame position, 24 per message
    sfp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_message_id     (i_message_id),
        .i_payload        (i_payload),
        .i_payload_length (i_payload_length),
        .i_channel_code   (r_channel_code),
        .i_full           (q_full),
        .o_push           (push),
        .o_tok            (push_tok)
    );

    sfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_tok   (head_tok),
        .o_empty (q_empty)
    );

    // back: escape insertion holds the head token for one extra beat
    sfp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok           (head_tok),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .i_send_checksum (r_send_checksum),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_frame_end     (o_frame_end)
    );

    // the final tail beat always carries the tail code
    a_last_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_out_byte == sfp_pkg::TAIL_BYTE))
        else $error("last beat is not a tail byte");

endmodule

// ----- dv/frame_byte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_checker: predicts and checks the packed byte stream
// Watches the message channel, the byte channel and the register port. Builds
// each frame from the accepted message and checks every output beat in order.
// ----------------------------------------------------------------------------
module frame_byte_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [sfp_pkg::ID_W-1:0]       i_message_id,
    input  logic [sfp_pkg::PAY_W-1:0]      i_payload,
    input  logic [sfp_pkg::LEN_W-1:0]      i_payload_length,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [sfp_pkg::BYTE_W-1:0]     i_out_byte,
    input  logic                           i_frame_end,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [sfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_frame_count,
    output int                             o_beat_count,
    output int                             o_escape_count
);

    typedef struct packed {
        logic [sfp_pkg::BYTE_W-1:0] data;
        logic                       last;
    } t_frame_beat;

    t_frame_beat                frame_beats_q[$];
    logic                       cks_enable;
    logic [sfp_pkg::BYTE_W-1:0] chan_byte;
    logic [sfp_pkg::BYTE_W-1:0] run_sum;
    int                         fails;
    int                         frames;
    int                         beats;
    int                         escapes;
    int                         pending_cnt;

    assign o_fail_count   = fails;
    assign o_pending      = pending_cnt;
    assign o_frame_count  = frames;
    assign o_beat_count   = beats;
    assign o_escape_count = escapes;

    function automatic void push_beat(logic [sfp_pkg::BYTE_W-1:0] b, logic last);
        frame_beats_q.push_back('{data: b, last: last});
    endfunction

    // field byte: stuffed if it looks like a framing byte, always summed
    function automatic void push_field_byte(logic [sfp_pkg::BYTE_W-1:0] b);
        if (b == sfp_pkg::HEAD_BYTE || b == sfp_pkg::TAIL_BYTE) begin
            push_beat(sfp_pkg::ESC_BYTE, 1'b0);
            escapes++;
        end
        push_beat(b, 1'b0);
        run_sum = run_sum + b;
    endfunction

    function automatic void pack_frame(logic [sfp_pkg::ID_W-1:0] id,
                                       logic [sfp_pkg::PAY_W-1:0] pay,
                                       logic [sfp_pkg::LEN_W-1:0] len_in);
        logic [sfp_pkg::LEN_W-1:0] len;
        logic [31:0]               id_word;
        logic [31:0]               len_word;
        int                        i;
        len      = (len_in > sfp_pkg::LEN_MAX) ? sfp_pkg::LEN_MAX : len_in;
        id_word  = 32'(id);
        len_word = 32'(len);
        run_sum  = '0;
        push_beat(sfp_pkg::HEAD_BYTE, 1'b0);
        push_beat(sfp_pkg::HEAD_BYTE, 1'b0);
        for (i = 0; i < 4; i++)
            push_field_byte(id_word[8*i +: 8]);
        // padding past the real length is plain zero
        for (i = 0; i < sfp_pkg::MAX_PAYLOAD; i++) begin
            if (i < len)
                push_field_byte(pay[8*i +: 8]);
            else
                push_beat(sfp_pkg::PAD_BYTE, 1'b0);
        end
        for (i = 0; i < 4; i++)
            push_field_byte(len_word[8*i +: 8]);
        push_beat(chan_byte, 1'b0);
        push_beat(sfp_pkg::FMT_EXTENDED, 1'b0);
        push_beat(sfp_pkg::FRAME_DATA, 1'b0);
        run_sum = run_sum + chan_byte + sfp_pkg::FMT_EXTENDED + sfp_pkg::FRAME_DATA;
        push_beat(cks_enable ? run_sum : '0, 1'b0);
        push_beat(sfp_pkg::TAIL_BYTE, 1'b0);
        push_beat(sfp_pkg::TAIL_BYTE, 1'b1);
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame_beat want;
        if (!i_rst_n) begin
            cks_enable = 1'b0;
            chan_byte  = sfp_pkg::CHANNEL_RESET;
            frame_beats_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                beats++;
                if (frame_beats_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected beat %02h end %0b, nothing pending",
                                 $realtime, i_out_byte, i_frame_end);
                end else begin
                    want = frame_beats_q.pop_front();
                    if (want.data !== i_out_byte || want.last !== i_frame_end) begin
                        fails++;
                        if (fails <= 10)
                            $display("[%0t] beat %0d: expected %02h end %0b, got %02h end %0b",
                                     $realtime, beats, want.data, want.last,
                                     i_out_byte, i_frame_end);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pack_frame(i_message_id, i_payload, i_payload_length);
                frames++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sfp_pkg::CFG_SEND_CHECKSUM: cks_enable = i_cfg_data[0];
                    sfp_pkg::CFG_CHANNEL_CODE:  chan_byte  = i_cfg_data[sfp_pkg::BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_cnt = frame_beats_q.size();
    end

endmodule

// ----- dv/stuffed_frame_packer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_packer_tb: stimulus and verdict for the stuffed frame packer
// Drives messages and register settings, random idling on both channels and
// one long output hold; a separate checker predicts and compares each beat.
// ----------------------------------------------------------------------------
module stuffed_frame_packer_tb;

    localparam int     CLK_HALF_NS      = 10;
    localparam int     RESET_CYCLES     = 3;
    localparam int     RANDOM_PHASES    = 5;
    localparam int     ITEMS_PER_PHASE  = 41;
    localparam int     LONG_HOLD_CYCLES = 160;
    localparam int     DRAIN_LIMIT      = 6000;
    localparam int     TAIL_CYCLES      = 10;    // margin before the final verdict
    // slowest legal run is well under 3 ms; allow several times that
    localparam longint TIMEOUT_NS       = 10_000_000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [sfp_pkg::ID_W-1:0]       message_id;
    logic [sfp_pkg::PAY_W-1:0]      payload;
    logic [sfp_pkg::LEN_W-1:0]      payload_length;
    logic                           out_valid;
    logic                           out_stall;
    logic [sfp_pkg::BYTE_W-1:0]     out_byte;
    logic                           frame_end;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [sfp_pkg::CFG_DATA_W-1:0] cfg_data;

    // control shared with the receiver process
    logic tx_idle_en    = 1'b1;
    logic rx_idle_en    = 1'b1;
    logic long_hold_req = 1'b0;
    logic drain_stuck   = 1'b0;
    int   settings_used = 0;

    int   fail_count;
    int   pending;
    int   frames;
    int   beats;
    int   escapes;

    stuffed_frame_packer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_message_id     (message_id),
        .i_payload        (payload),
        .i_payload_length (payload_length),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_byte       (out_byte),
        .o_frame_end      (frame_end),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    frame_byte_checker frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_message_id     (message_id),
        .i_payload        (payload),
        .i_payload_length (payload_length),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_byte       (out_byte),
        .i_frame_end      (frame_end),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_frame_count    (frames),
        .o_beat_count     (beats),
        .o_escape_count   (escapes)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    // hard stop in case a handshake never completes
    initial begin
        #TIMEOUT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Byte side: bursts of stall or no stall of random length, each value driven at
    // falling edges so only one assignment lands per step. A long hold, when asked
    // for, is counted here and lets the block fill and stall its input.
    initial begin : out_side
        int   n;
        logic v;
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            if (long_hold_req && !hold_done) begin
                v         = 1'b1;
                n         = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                v = 1'b1;
                n = $urandom_range(1, 12);
            end else begin
                v = 1'b0;
                n = $urandom_range(1, 16);
            end
            repeat (n) begin
                @(negedge i_clk);
                out_stall <= v;
            end
        end
    end

    // byte value biased towards the framing and escape codes
    function automatic logic [sfp_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return sfp_pkg::HEAD_BYTE;
            1:       return sfp_pkg::TAIL_BYTE;
            2:       return sfp_pkg::ESC_BYTE;
            3:       return 8'h00;
            4:       return 8'hFF;
            default: return sfp_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    // One message beat: optional idle burst first (fields carry junk while
    // valid is low), then hold the message until it is taken.
    task automatic offer_message(logic [sfp_pkg::ID_W-1:0] id,
                                 logic [sfp_pkg::PAY_W-1:0] pay,
                                 logic [sfp_pkg::LEN_W-1:0] len);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid       <= 1'b0;
                message_id     <= sfp_pkg::ID_W'($urandom);
                payload        <= {$urandom, $urandom};
                payload_length <= sfp_pkg::LEN_W'($urandom);
            end
        end
        @(negedge i_clk);
        in_valid       <= 1'b1;
        message_id     <= id;
        payload        <= pay;
        payload_length <= len;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
    endtask

    task automatic offer_random();
        logic [31:0]               id_w;
        logic [sfp_pkg::PAY_W-1:0] pay;
        logic [sfp_pkg::LEN_W-1:0] len;
        int                        i;
        if ($urandom_range(0, 1)) begin
            id_w = $urandom;
        end else begin
            for (i = 0; i < 4; i++)
                id_w[8*i +: 8] = pick_byte();
        end
        if ($urandom_range(0, 1)) begin
            pay = {$urandom, $urandom};
        end else begin
            for (i = 0; i < sfp_pkg::MAX_PAYLOAD; i++)
                pay[8*i +: 8] = pick_byte();
        end
        // mostly legal lengths, now and then one that must saturate
        if ($urandom_range(0, 7) == 0)
            len = sfp_pkg::LEN_W'($urandom_range(9, 15));
        else
            len = sfp_pkg::LEN_W'($urandom_range(0, 8));
        offer_message(id_w[sfp_pkg::ID_W-1:0], pay, len);
    endtask

    // extremes, stuffed fields, padding, saturated length, each legal length
    task automatic run_directed();
        offer_message('0, '0, 4'd0);
        offer_message('1, '1, sfp_pkg::LEN_MAX);
        offer_message(30'h2AAA_55AA, 64'hAA55_AA55_55AA_AA55, sfp_pkg::LEN_MAX);
        // framing bytes in the padding area must come out as plain zeros
        offer_message(30'h0000_00A5, 64'hAAAA_AAAA_AAAA_AAAA, 4'd3);
        offer_message(30'h1234_5678, 64'h5555_5555_5555_5555, 4'd9);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd15);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd1);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd2);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd4);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd5);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd6);
        offer_message(sfp_pkg::ID_W'($urandom), {$urandom, $urandom}, 4'd7);
    endtask

    // drop valid and wait for every predicted beat to come out
    task automatic finish_phase();
        int k;
        @(negedge i_clk);
        in_valid <= 1'b0;
        k = 0;
        while (pending != 0 && k < DRAIN_LIMIT) begin
            @(negedge i_clk);
            k++;
        end
        if (pending != 0)
            drain_stuck = 1'b1;
    endtask

    task automatic write_reg(logic idx, logic [sfp_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(logic cks, logic [sfp_pkg::BYTE_W-1:0] ch);
        write_reg(sfp_pkg::CFG_SEND_CHECKSUM, sfp_pkg::CFG_DATA_W'(cks));
        write_reg(sfp_pkg::CFG_CHANNEL_CODE, sfp_pkg::CFG_DATA_W'(ch));
        settings_used++;
    endtask

    initial begin : stimulus
        int                         p;
        int                         k;
        logic                       cks;
        logic [sfp_pkg::BYTE_W-1:0] ch;
        in_valid       = 1'b0;
        message_id     = '0;
        payload        = '0;
        payload_length = '0;
        cfg_we         = 1'b0;
        cfg_index      = sfp_pkg::CFG_SEND_CHECKSUM;
        cfg_data       = '0;
        i_rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero checksum, default channel
        run_directed();
        finish_phase();
        // checksum on, channel byte equal to the header code (sent unstuffed)
        apply_setting(1'b1, sfp_pkg::HEAD_BYTE);
        run_directed();
        finish_phase();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin cks = 1'b1; ch = 8'h00;              end
                1:       begin cks = 1'b0; ch = 8'hFF;              end
                2:       begin cks = 1'b1; ch = sfp_pkg::TAIL_BYTE; end
                3:       begin cks = 1'b1; ch = 8'hFF;              end
                default: begin
                    cks = 1'($urandom_range(0, 1));
                    ch  = sfp_pkg::BYTE_W'($urandom);
                end
            endcase
            // final stretch runs flat out on both sides
            if (p == RANDOM_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            apply_setting(cks, ch);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 1 && k == 3)
                    long_hold_req = 1'b1;
                offer_random();
            end
            finish_phase();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Run covered %0d messages, %0d output beats (%0d stuffing escapes),",
                 frames, beats, escapes);
        $display("%0d register settings, field extremes, saturated lengths, long hold",
                 settings_used + 1);
        if (fail_count == 0 && pending == 0 && !drain_stuck)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
